// ----- src/tps_pkg.sv -----
// Shared types, codes and helpers of the timed pour sequencer.
// Used by tps_cfg, tps_step and timed_pour_sequencer; no dependencies.
`timescale 1ns / 1ps
package tps_pkg;

	localparam int unsigned TIME_W   = 20;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned IN_DATA_W = 8;
	localparam int unsigned IN_USER_W = 3;
	localparam int unsigned OUT_DATA_W = 16;

	localparam logic [TIME_W-1:0] MS_MAX = {TIME_W{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_ONE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_TWO  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX_FIRST = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX_SECOND = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PUMP_TWO  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL     = 3'd5;

	// item kinds
	localparam logic [2:0] KIND_TICK   = 3'd0;
	localparam logic [2:0] KIND_START  = 3'd1;
	localparam logic [2:0] KIND_ABORT  = 3'd2;
	localparam logic [2:0] KIND_LOCK   = 3'd3;
	localparam logic [2:0] KIND_UNLOCK = 3'd4;

	// drinks
	localparam logic [1:0] DRINK_ONE = 2'd0;
	localparam logic [1:0] DRINK_TWO = 2'd1;
	localparam logic [1:0] DRINK_MIX = 2'd2;
	localparam logic [1:0] DRINK_ALT = 2'd3;

	// phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DOWN = 2'd1;
	localparam logic [1:0] PH_POUR = 2'd2;
	localparam logic [1:0] PH_UP   = 2'd3;

	// gantry commands
	localparam logic [1:0] GD_STOP = 2'd0;
	localparam logic [1:0] GD_DOWN = 2'd1;
	localparam logic [1:0] GD_UP   = 2'd2;

	// LED codes
	localparam logic [2:0] LED_NONE     = 3'd0;
	localparam logic [2:0] LED_LOCAL    = 3'd4;
	localparam logic [2:0] LED_EXTERNAL = 3'd5;
	localparam logic [2:0] LED_LOCKOUT  = 3'd6;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NEED_P2 = 3'd1;
	localparam logic [2:0] ST_BUSY    = 3'd2;
	localparam logic [2:0] ST_LOCKED  = 3'd3;
	localparam logic [2:0] ST_NO_POUR = 3'd4;

	typedef struct packed {
		logic [TIME_W-1:0] time_single_one;
		logic [TIME_W-1:0] time_single_two;
		logic [TIME_W-1:0] time_mix_first;
		logic [TIME_W-1:0] time_mix_second;
		logic              second_pump_fitted;
		logic              served_locally;
	} cfg_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [1:0] drink;
		logic       bottom_reached;
		logic       top_reached;
		logic       cancel_pressed;
	} item_t;

	typedef struct packed {
		logic [1:0]        phase;
		logic [1:0]        drink;
		logic [TIME_W-1:0] elapsed;
		logic              locked;
		logic [1:0]        gantry;
		logic              pump_one;
		logic              pump_two;
		logic [2:0]        led;
	} state_t;

	typedef struct packed {
		logic [2:0] status;
		logic       locked;
		logic [1:0] phase;
		logic [2:0] led_code;
		logic       pump_two_on;
		logic       pump_one_on;
		logic [1:0] gantry_drive;
	} result_t;

	function automatic logic [2:0] idle_led(input logic served_locally);
		return served_locally ? LED_LOCAL : LED_EXTERNAL;
	endfunction

endpackage

// ----- src/timed_pour_sequencer.sv -----
// Top level of the timed pour sequencer: input register, step logic, state and result register.
// Depends on tps_pkg, tps_cfg and tps_step.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one item per beat: tuser holds the kind (tick, start, abort,
//   lock, unlock), tdata the drink and the switch and button levels of a tick.
//   m_axis returns exactly one result beat per input beat, in order.
//   cfg writes one of six registers by index; always ready. Write it only while
//   no result is outstanding.
// Path: an accepted beat is registered in the input register, its result in the result
//   register, which drives m_axis.
// Throughput: one item per cycle while m_axis_tready holds; the step logic is a few compares
//   on the 20-bit elapsed count between the input and result registers.
// Reset: all state clears: idle phase, gantry stopped, pumps off, LED none,
//   unlocked, all configuration zero. Both pipeline stages empty.
// Stall: a held result keeps m_axis_tdata stable; the input register still
//   takes a beat, then s_axis_tready drops until the result is taken.
module timed_pour_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [1:0] drink, [2] bottom_reached, [3] top_reached, [4] cancel_pressed
	input  logic [tps_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// [2:0] kind
	input  logic [tps_pkg::IN_USER_W-1:0]     s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [1:0] gantry_drive, [2] pump_one_on, [3] pump_two_on, [6:4] led_code,
	// [8:7] phase, [9] locked, [12:10] status
	output logic [tps_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tps_pkg::TIME_W-1:0]        cfg_data
);
	import tps_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    vld_s1;
	result_t res_s2;
	logic    vld_s2;
	state_t  st_q;
	state_t  st_nx;
	result_t res_nx;
	logic    advance;

	assign cfg_ready = 1'b1;

	tps_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	tps_step u_step (
		.cfg   (cfg),
		.st    (st_q),
		.item  (item_s1),
		.st_nx (st_nx),
		.res   (res_nx)
	);

	assign advance       = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.kind           <= s_axis_tuser[2:0];
			item_s1.drink          <= s_axis_tdata[1:0];
			item_s1.bottom_reached <= s_axis_tdata[2];
			item_s1.top_reached    <= s_axis_tdata[3];
			item_s1.cancel_pressed <= s_axis_tdata[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '0;
			vld_s2 <= 1'b0;
		end else begin
			if (advance)
				st_q <= st_nx;
			if (advance)
				vld_s2 <= 1'b1;
			else if (m_axis_tready)
				vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_nx;
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, res_s2};

	a_locked_tick_holds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.kind == KIND_TICK && st_q.locked |=> $stable(st_q))
		else $error("locked tick changed state");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_axis_tvalid)
		else $error("advanced item produced no result");

	a_pour_gantry_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_POUR |-> st_q.gantry == GD_STOP)
		else $error("gantry moving while pouring");

	a_locked_led: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.kind == KIND_LOCK |=> st_q.locked && st_q.led == LED_LOCKOUT)
		else $error("lock did not take effect");

endmodule

// ----- src/tps_cfg.sv -----
// Configuration register file of the timed pour sequencer.
// Depends on tps_pkg.
`timescale 1ns / 1ps
module tps_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [tps_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [tps_pkg::TIME_W-1:0]     wr_data,
	output tps_pkg::cfg_t                  cfg
);
	import tps_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_TIME_ONE:   cfg_q.time_single_one <= wr_data;
				CFG_TIME_TWO:   cfg_q.time_single_two <= wr_data;
				CFG_MIX_FIRST:  cfg_q.time_mix_first <= wr_data;
				CFG_MIX_SECOND: cfg_q.time_mix_second <= wr_data;
				CFG_PUMP_TWO:   cfg_q.second_pump_fitted <= wr_data[0];
				CFG_LOCAL:      cfg_q.served_locally <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/tps_step.sv -----
// Next-state and result logic for one item of the timed pour sequencer.
// Depends on tps_pkg.
`timescale 1ns / 1ps
module tps_step (
	input  tps_pkg::cfg_t    cfg,
	input  tps_pkg::state_t  st,
	input  tps_pkg::item_t   item,
	output tps_pkg::state_t  st_nx,
	output tps_pkg::result_t res
);
	import tps_pkg::*;

	function automatic state_t abort_f(input state_t s, input cfg_t c);
		state_t r;
		r = s;
		r.pump_one = 1'b0;
		if (c.second_pump_fitted)
			r.pump_two = 1'b0;
		if (!s.locked) begin
			r.gantry = GD_UP;
			r.phase  = PH_UP;
			r.led    = idle_led(c.served_locally);
		end else begin
			r.gantry = GD_STOP;
			r.phase  = PH_IDLE;
		end
		return r;
	endfunction

	state_t            nx;
	logic [2:0]        status;
	logic [1:0]        drk;
	logic [TIME_W-1:0] el_inc;
	logic              d1;
	logic              d2;
	logic              done;

	always_comb begin
		nx     = st;
		status = ST_OK;
		drk    = (item.drink == DRINK_ALT) ? DRINK_MIX : item.drink;
		el_inc = (st.elapsed != MS_MAX) ? st.elapsed + TIME_W'(1) : st.elapsed;
		d1     = 1'b0;
		d2     = 1'b0;
		case (st.drink)
			DRINK_ONE: begin
				d1 = el_inc >= cfg.time_single_one;
				done = d1;
			end
			DRINK_TWO: begin
				d2 = el_inc >= cfg.time_single_two;
				done = d2;
			end
			default: begin
				d1 = el_inc >= cfg.time_mix_first;
				d2 = el_inc >= cfg.time_mix_second;
				done = d1 && d2;
			end
		endcase

		case (item.kind)
			KIND_TICK: begin
				if (!st.locked) begin
					case (st.phase)
						PH_DOWN: begin
							if (item.bottom_reached) begin
								nx.elapsed = '0;
								if (item.cancel_pressed) begin
									nx = abort_f(nx, cfg);
								end else begin
									nx.gantry = GD_STOP;
									if (st.drink != DRINK_TWO)
										nx.pump_one = 1'b1;
									if (st.drink != DRINK_ONE)
										nx.pump_two = 1'b1;
									nx.phase = PH_POUR;
								end
							end else begin
								nx.gantry = GD_DOWN;
							end
						end
						PH_POUR: begin
							nx.elapsed = el_inc;
							if (d1)
								nx.pump_one = 1'b0;
							if (d2)
								nx.pump_two = 1'b0;
							if (done) begin
								nx.gantry = GD_UP;
								nx.phase  = PH_UP;
							end
						end
						PH_UP: begin
							if (item.top_reached) begin
								nx.gantry = GD_STOP;
								nx.phase  = PH_IDLE;
								nx.led    = idle_led(cfg.served_locally);
							end else begin
								nx.gantry = GD_UP;
							end
						end
						default: ;
					endcase
				end
			end
			KIND_START: begin
				if (drk != DRINK_ONE && !cfg.second_pump_fitted) begin
					status = ST_NEED_P2;
				end else if (st.phase != PH_IDLE) begin
					status = ST_BUSY;
				end else if (st.locked) begin
					status = ST_LOCKED;
				end else begin
					nx.drink  = drk;
					nx.gantry = GD_DOWN;
					nx.led    = {1'b0, drk} + 3'd1;
					nx.phase  = PH_DOWN;
				end
			end
			KIND_ABORT: begin
				if (st.phase == PH_IDLE)
					status = ST_NO_POUR;
				else
					nx = abort_f(st, cfg);
			end
			KIND_LOCK: begin
				if (st.phase != PH_IDLE)
					nx = abort_f(st, cfg);
				nx.locked = 1'b1;
				nx.led    = LED_LOCKOUT;
			end
			KIND_UNLOCK: begin
				nx.locked = 1'b0;
				nx.led    = idle_led(cfg.served_locally);
			end
			default: ;
		endcase
	end

	assign st_nx = nx;

	always_comb begin
		res.gantry_drive = nx.gantry;
		res.pump_one_on  = nx.pump_one;
		res.pump_two_on  = nx.pump_two;
		res.led_code     = nx.led;
		res.phase        = nx.phase;
		res.locked       = nx.locked;
		res.status       = status;
	end

endmodule

// ----- tb/sv/pour_checker.sv -----
// Checker for the timed pour sequencer: watches the input, result and register channels,
// predicts each result beat from its own copy of the sequencer state and compares fields.
// Depends on tps_pkg for the item, result and register layouts and their codes.
`timescale 1ns / 1ps
module pour_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [tps_pkg::IN_DATA_W-1:0] in_data,
	input  logic [tps_pkg::IN_USER_W-1:0] in_user,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [tps_pkg::OUT_DATA_W-1:0] out_data,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [tps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tps_pkg::TIME_W-1:0]    cfg_data,
	output int                            errors,
	output int                            pending
);
	import tps_pkg::*;

	cfg_t               cfg_q;
	logic [1:0]         phase_q;
	logic [1:0]         drink_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic               lock_q;
	logic [1:0]         gantry_q;
	logic               pump1_q;
	logic               pump2_q;
	logic [2:0]         led_q;
	result_t            results_due[$];

	function automatic logic [2:0] rest_led();
		return cfg_q.served_locally ? LED_LOCAL : LED_EXTERNAL;
	endfunction

	function automatic logic [2:0] cut_pour();
		if (phase_q == PH_IDLE)
			return ST_NO_POUR;
		pump1_q = 1'b0;
		if (cfg_q.second_pump_fitted)
			pump2_q = 1'b0;
		if (!lock_q) begin
			gantry_q = GD_UP;
			phase_q  = PH_UP;
			led_q    = rest_led();
		end else begin
			gantry_q = GD_STOP;
			phase_q  = PH_IDLE;
		end
		return ST_OK;
	endfunction

	function automatic result_t pour_step(item_t it);
		result_t    r;
		logic [1:0] d;
		logic       done;
		logic       d1;
		logic       d2;
		logic [2:0] st;
		st = ST_OK;
		done = 1'b0;
		case (it.kind)
			KIND_TICK: if (!lock_q) begin
				case (phase_q)
					PH_DOWN: if (it.bottom_reached) begin
						elapsed_q = '0;
						if (it.cancel_pressed) begin
							void'(cut_pour());
						end else begin
							gantry_q = GD_STOP;
							if (drink_q != DRINK_TWO)
								pump1_q = 1'b1;
							if (drink_q != DRINK_ONE)
								pump2_q = 1'b1;
							phase_q = PH_POUR;
						end
					end else begin
						gantry_q = GD_DOWN;
					end
					PH_POUR: begin
						if (elapsed_q != MS_MAX)
							elapsed_q = elapsed_q + TIME_W'(1);
						case (drink_q)
							DRINK_ONE: begin
								done = elapsed_q >= cfg_q.time_single_one;
								if (done)
									pump1_q = 1'b0;
							end
							DRINK_TWO: begin
								done = elapsed_q >= cfg_q.time_single_two;
								if (done)
									pump2_q = 1'b0;
							end
							default: begin
								d1 = elapsed_q >= cfg_q.time_mix_first;
								d2 = elapsed_q >= cfg_q.time_mix_second;
								if (d1)
									pump1_q = 1'b0;
								if (d2)
									pump2_q = 1'b0;
								done = d1 && d2;
							end
						endcase
						if (done) begin
							gantry_q = GD_UP;
							phase_q  = PH_UP;
						end
					end
					PH_UP: if (it.top_reached) begin
						gantry_q = GD_STOP;
						phase_q  = PH_IDLE;
						led_q    = rest_led();
					end else begin
						gantry_q = GD_UP;
					end
					default: ;
				endcase
			end
			KIND_START: begin
				d = (it.drink == DRINK_ALT) ? DRINK_MIX : it.drink;
				if (d != DRINK_ONE && !cfg_q.second_pump_fitted)
					st = ST_NEED_P2;
				else if (phase_q != PH_IDLE)
					st = ST_BUSY;
				else if (lock_q)
					st = ST_LOCKED;
				else begin
					drink_q  = d;
					gantry_q = GD_DOWN;
					led_q    = {1'b0, d} + 3'd1;
					phase_q  = PH_DOWN;
				end
			end
			KIND_ABORT: st = cut_pour();
			KIND_LOCK: begin
				void'(cut_pour());
				lock_q = 1'b1;
				led_q  = LED_LOCKOUT;
			end
			KIND_UNLOCK: begin
				lock_q = 1'b0;
				led_q  = rest_led();
			end
			default: ;
		endcase
		r.gantry_drive = gantry_q;
		r.pump_one_on  = pump1_q;
		r.pump_two_on  = pump2_q;
		r.led_code     = led_q;
		r.phase        = phase_q;
		r.locked       = lock_q;
		r.status       = st;
		return r;
	endfunction

	function automatic void check_field(string what, logic [2:0] want_v, logic [2:0] got_v);
		if (want_v !== got_v) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t got;
		item_t   it;
		if (!arst_n) begin
			cfg_q     = '0;
			phase_q   = PH_IDLE;
			drink_q   = DRINK_ONE;
			elapsed_q = '0;
			lock_q    = 1'b0;
			gantry_q  = GD_STOP;
			pump1_q   = 1'b0;
			pump2_q   = 1'b0;
			led_q     = LED_NONE;
			errors    = 0;
			results_due.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = result_t'(out_data[$bits(result_t)-1:0]);
				if (results_due.size() == 0) begin
					errors++;
					$display("%0t: result beat %h expected none", $time, out_data);
				end else begin
					want = results_due.pop_front();
					check_field("gantry_drive", 3'(want.gantry_drive), 3'(got.gantry_drive));
					check_field("pump_one_on", 3'(want.pump_one_on), 3'(got.pump_one_on));
					check_field("pump_two_on", 3'(want.pump_two_on), 3'(got.pump_two_on));
					check_field("led_code", want.led_code, got.led_code);
					check_field("phase", 3'(want.phase), 3'(got.phase));
					check_field("locked", 3'(want.locked), 3'(got.locked));
					check_field("status", want.status, got.status);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TIME_ONE:   cfg_q.time_single_one    = cfg_data;
					CFG_TIME_TWO:   cfg_q.time_single_two    = cfg_data;
					CFG_MIX_FIRST:  cfg_q.time_mix_first     = cfg_data;
					CFG_MIX_SECOND: cfg_q.time_mix_second    = cfg_data;
					CFG_PUMP_TWO:   cfg_q.second_pump_fitted = cfg_data[0];
					CFG_LOCAL:      cfg_q.served_locally     = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				it.kind           = in_user[2:0];
				it.drink          = in_data[1:0];
				it.bottom_reached = in_data[2];
				it.top_reached    = in_data[3];
				it.cancel_pressed = in_data[4];
				results_due.push_back(pour_step(it));
			end
			pending <= results_due.size();
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for timed_pour_sequencer: clock, reset, directed and random pour stimulus,
// random idling on both streams and the verdict. Depends on tps_pkg and pour_checker.
`timescale 1ns / 1ps
module tb;
	import tps_pkg::*;

	localparam int LIMIT = 200000;
	localparam int RUN_ITEMS = 125;
	localparam logic [2:0] KIND_LAST = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [TIME_W-1:0]     cfg_data = '0;

	int send_gap_pct = 0;
	int stall_pct = 0;
	int sent = 0;
	int cycles = 0;
	int errors;
	int pending;

	always #5 clk = ~clk;

	timed_pour_sequencer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	pour_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic put_item(input logic [2:0] kind, input logic [1:0] drink,
			input logic bottom, input logic top, input logic cancel);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, cancel, top, bottom, drink};
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	task automatic tick(input logic bottom, input logic top, input logic cancel);
		put_item(KIND_TICK, 2'($urandom_range(0, 3)), bottom, top, cancel);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_setting(input logic [TIME_W-1:0] t1, input logic [TIME_W-1:0] t2,
			input logic [TIME_W-1:0] m1, input logic [TIME_W-1:0] m2,
			input logic p2, input logic loc);
		logic [TIME_W-1:0] w;
		settle();
		write_reg(CFG_TIME_ONE, t1);
		write_reg(CFG_TIME_TWO, t2);
		write_reg(CFG_MIX_FIRST, m1);
		write_reg(CFG_MIX_SECOND, m2);
		w = TIME_W'($urandom);
		w[0] = p2;
		write_reg(CFG_PUMP_TWO, w);
		w = TIME_W'($urandom);
		w[0] = loc;
		write_reg(CFG_LOCAL, w);
		cfg_valid <= 1'b0;
	endtask

	task automatic noise_item();
		int r;
		logic [2:0] kind;
		r = $urandom_range(0, 99);
		if (r < 40)
			kind = KIND_TICK;
		else if (r < 55)
			kind = KIND_START;
		else if (r < 70)
			kind = KIND_ABORT;
		else if (r < 80)
			kind = KIND_LOCK;
		else if (r < 95)
			kind = KIND_UNLOCK;
		else
			kind = 3'($urandom_range(KIND_UNLOCK + 1, KIND_LAST));
		put_item(kind, 2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// start, descend, pour, rise, with random levels and the odd cancel or abort
	task automatic pour_run();
		if ($urandom_range(0, 2) == 0)
			put_item(KIND_UNLOCK, 2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
				1'($urandom));
		put_item(KIND_START, 2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
			1'($urandom));
		repeat ($urandom_range(0, 3))
			tick(1'b0, 1'($urandom), 1'($urandom));
		tick(1'b1, 1'($urandom), $urandom_range(0, 9) == 0);
		repeat ($urandom_range(1, 8))
			tick(1'($urandom), 1'b0, 1'($urandom));
		if ($urandom_range(0, 5) == 0)
			put_item(KIND_ABORT, 2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
				1'($urandom));
		repeat ($urandom_range(0, 2))
			tick(1'($urandom), 1'b0, 1'($urandom));
		tick(1'($urandom), 1'b1, 1'($urandom));
	endtask

	initial begin : stimulus
		int goal;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no second pump yet, nothing pouring
		put_item(KIND_START, DRINK_TWO, 1'b0, 1'b0, 1'b0);
		put_item(KIND_ABORT, DRINK_ONE, 1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b1, 1'b1);
		for (int k = int'(KIND_UNLOCK) + 1; k <= int'(KIND_LAST); k++)
			put_item(3'(k), DRINK_ALT, 1'b1, 1'b1, 1'b1);

		apply_setting(20'd2, 20'd0, 20'd1, 20'd3, 1'b1, 1'b0);
		write_reg(CFG_UNUSED, MS_MAX);
		cfg_valid <= 1'b0;

		put_item(KIND_START, DRINK_ONE, 1'b0, 1'b0, 1'b0);
		put_item(KIND_START, DRINK_ONE, 1'b0, 1'b0, 1'b0);
		tick(1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b0);
		tick(1'b0, 1'b0, 1'b0);
		tick(1'b0, 1'b0, 1'b0);
		tick(1'b0, 1'b0, 1'b0);
		tick(1'b0, 1'b1, 1'b0);
		put_item(KIND_START, DRINK_ALT, 1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b1);
		tick(1'b0, 1'b1, 1'b0);
		put_item(KIND_LOCK, DRINK_ONE, 1'b0, 1'b0, 1'b0);
		put_item(KIND_START, DRINK_ONE, 1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b1, 1'b1);
		put_item(KIND_UNLOCK, DRINK_ONE, 1'b0, 1'b0, 1'b0);
		put_item(KIND_START, DRINK_TWO, 1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b0);
		tick(1'b0, 1'b0, 1'b0);
		put_item(KIND_ABORT, DRINK_ONE, 1'b0, 1'b0, 1'b0);
		put_item(KIND_LOCK, DRINK_ONE, 1'b0, 1'b0, 1'b0);
		put_item(KIND_ABORT, DRINK_ONE, 1'b0, 1'b0, 1'b0);
		put_item(KIND_UNLOCK, DRINK_ONE, 1'b0, 1'b0, 1'b0);

		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin
					apply_setting('0, MS_MAX, MS_MAX, '0, 1'b1, 1'b1);
					send_gap_pct <= 0;
					stall_pct    <= 0;
				end
				1: begin
					apply_setting(TIME_W'($urandom_range(0, 8)), TIME_W'($urandom_range(0, 8)),
						TIME_W'($urandom_range(0, 8)), TIME_W'($urandom_range(0, 8)),
						1'b0, 1'b0);
					send_gap_pct <= 56;
					stall_pct    <= 0;
				end
				2: begin
					apply_setting(TIME_W'($urandom_range(0, 8)), TIME_W'($urandom_range(0, 8)),
						TIME_W'($urandom_range(0, 8)), TIME_W'($urandom_range(0, 8)),
						1'b1, 1'($urandom));
					send_gap_pct <= 0;
					stall_pct    <= 56;
				end
				default: begin
					apply_setting(TIME_W'($urandom_range(0, 8)), TIME_W'($urandom_range(0, 8)),
						TIME_W'($urandom_range(0, 8)), TIME_W'($urandom_range(0, 8)),
						1'($urandom), 1'($urandom));
					send_gap_pct <= 8;
					stall_pct    <= 8;
				end
			endcase
			goal = sent + RUN_ITEMS;
			while (sent < goal) begin
				if ($urandom_range(0, 3) != 0)
					pour_run();
				else
					noise_item();
			end
		end

		settle();
		repeat (4) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
